### design/assert_macros.svh
// assertion helpers used by the top-level rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock out of reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/aacrtp_pkg.sv
`default_nettype none
package aacrtp_pkg;

  // prefix bytes ahead of each fragment payload
  localparam int HDR_BYTES = 20;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [7:0] DOLLAR_BYTE = 8'h24;
  localparam logic [7:0] RTP_VER_BYTE = 8'h80;
  localparam logic [7:0] AU_LEN_BYTE = 8'h10;

  // reciprocal of 1000 scaled by 2^27, exact for 17-bit rates
  localparam logic [17:0] RECIP_1000 = 18'd134218;
  localparam int RECIP_SHIFT = 27;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_MTU     = 3'd0,
    REG_RATE    = 3'd1,
    REG_PT      = 3'd2,
    REG_CHANNEL = 3'd3,
    REG_SSRC    = 3'd4,
    REG_CYCLE   = 3'd5
  } reg_idx_t;

  // one queued frame byte with its packet context
  typedef struct packed {
    logic [7:0]  data;
    logic        hdr;
    logic        mark;
    logic [11:0] len;
    logic        plast;
    logic        flast;
    logic [31:0] rtp;
    logic [12:0] fsize;
  } entry_t;

endpackage
`default_nettype wire

### design/aacrtp_queue.sv
`default_nettype none
module aacrtp_queue #(
  parameter int DEPTH = 4
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  wire aacrtp_pkg::entry_t wdata,
  output logic                  full,
  input  wire                   pop,
  output aacrtp_pkg::entry_t    rdata,
  output logic                  empty
);
  import aacrtp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CW'(push && !full) - CW'(pop && !empty);
    end
  end
endmodule
`default_nettype wire

### design/aacrtp_front.sv
`default_nettype none
module aacrtp_front (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [7:0]            data_byte,
  input  wire  [12:0]           frame_length,
  input  wire  [31:0]           timestamp_ms,
  input  wire  [10:0]           mtu_size,
  input  wire  [16:0]           sample_rate,
  input  wire  [31:0]           cycle_ms,
  output logic                  push,
  output aacrtp_pkg::entry_t    wdata,
  input  wire                   full
);
  import aacrtp_pkg::*;

  typedef enum logic [1:0] {S_ACC, S_DIV, S_MUL, S_PROC} state_t;

  state_t      state;
  logic [12:0] fbl;
  logic [10:0] frag;
  logic [12:0] fsize;
  logic [31:0] rtp;
  logic [7:0]  pend_data;
  logic [31:0] dvd;
  logic [32:0] rem;
  logic [4:0]  cnt;
  logic [31:0] tval;
  logic [7:0]  rate_k;

  logic [34:0] rate_prod;
  logic [39:0] rtp_prod;
  logic [32:0] rem_sh;
  logic [32:0] rem_next;
  logic [10:0] maxpl;
  logic [10:0] chunk;
  logic [10:0] frag_eff;
  logic [10:0] frag_next;
  logic [12:0] fbl_next;
  logic        pkt_start;

  // rate in samples per millisecond, registered
  assign rate_prod = 35'(sample_rate) * 35'(RECIP_1000);
  always_ff @(posedge clk) begin
    rate_k <= rate_prod[RECIP_SHIFT +: 8];
  end

  // one restoring step of timestamp mod cycle
  assign rem_sh   = {rem[31:0], dvd[31]};
  assign rem_next = (rem_sh >= {1'b0, cycle_ms}) ? rem_sh - {1'b0, cycle_ms} : rem_sh;

  assign rtp_prod = 40'(rate_k) * 40'(tval);

  // fragment bookkeeping for the byte at hand
  assign maxpl     = (mtu_size > 11'd20) ? mtu_size - 11'd20 : 11'd1;
  assign pkt_start = (frag == '0);
  assign chunk     = (fbl <= {2'b00, maxpl}) ? fbl[10:0] : maxpl;
  assign frag_eff  = pkt_start ? chunk : frag;
  assign frag_next = frag_eff - 11'd1;
  assign fbl_next  = fbl - 13'd1;

  assign in_ready = (state == S_ACC) && !full;
  assign push = ((state == S_ACC) && in_valid && in_ready && (fbl != '0)) ||
                ((state == S_PROC) && !full);

  always_comb begin
    wdata.data  = (state == S_PROC) ? pend_data : data_byte;
    wdata.hdr   = pkt_start;
    wdata.mark  = ({2'b00, chunk} == fbl);
    wdata.len   = {1'b0, chunk} + 12'd16;
    wdata.plast = (frag_next == '0);
    wdata.flast = (fbl_next == '0);
    wdata.rtp   = rtp;
    wdata.fsize = fsize;
  end

  // sequencer: accept, wrap timestamp unless cycle_ms is zero, scale, place first byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      fbl   <= '0;
      frag  <= '0;
      fsize <= '0;
      rtp   <= '0;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_ACC: begin
          if (in_valid && in_ready) begin
            if (fbl == '0) begin
              if (frame_length != '0) begin
                pend_data <= data_byte;
                fsize     <= frame_length;
                fbl       <= frame_length;
                frag      <= '0;
                if (cycle_ms == '0) begin
                  tval  <= timestamp_ms;
                  state <= S_MUL;
                end else begin
                  dvd   <= timestamp_ms;
                  rem   <= '0;
                  cnt   <= '0;
                  state <= S_DIV;
                end
              end
            end else begin
              fbl  <= fbl_next;
              frag <= frag_next;
            end
          end
        end
        S_DIV: begin
          rem <= rem_next;
          dvd <= {dvd[30:0], 1'b0};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            tval  <= rem_next[31:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          rtp   <= rtp_prod[31:0];
          state <= S_PROC;
        end
        S_PROC: begin
          if (!full) begin
            fbl   <= fbl_next;
            frag  <= frag_next;
            state <= S_ACC;
          end
        end
        default: state <= S_ACC;
      endcase
    end
  end
endmodule
`default_nettype wire

### design/aacrtp_back.sv
`default_nettype none
module aacrtp_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire aacrtp_pkg::entry_t head,
  input  wire                   empty,
  output logic                  pop,
  input  wire  [6:0]            payload_type,
  input  wire  [7:0]            channel_id,
  input  wire  [31:0]           stream_ssrc,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [7:0]            out_byte,
  output logic                  packet_last,
  output logic                  frame_last
);
  import aacrtp_pkg::*;

  logic [4:0]  idx;
  logic [15:0] seq;
  logic [7:0]  sel;
  logic        load;
  logic        in_hdr;

  assign load   = !out_valid || out_ready;
  assign in_hdr = head.hdr && (idx < 5'(HDR_BYTES));
  assign pop    = load && !empty && !in_hdr;

  // prefix byte picker
  always_comb begin
    case (idx)
      5'd0:    sel = DOLLAR_BYTE;
      5'd1:    sel = channel_id;
      5'd2:    sel = {4'h0, head.len[11:8]};
      5'd3:    sel = head.len[7:0];
      5'd4:    sel = RTP_VER_BYTE;
      5'd5:    sel = {head.mark, payload_type};
      5'd6:    sel = seq[15:8];
      5'd7:    sel = seq[7:0];
      5'd8:    sel = head.rtp[31:24];
      5'd9:    sel = head.rtp[23:16];
      5'd10:   sel = head.rtp[15:8];
      5'd11:   sel = head.rtp[7:0];
      5'd12:   sel = stream_ssrc[31:24];
      5'd13:   sel = stream_ssrc[23:16];
      5'd14:   sel = stream_ssrc[15:8];
      5'd15:   sel = stream_ssrc[7:0];
      5'd16:   sel = 8'h00;
      5'd17:   sel = AU_LEN_BYTE;
      5'd18:   sel = head.fsize[12:5];
      5'd19:   sel = {head.fsize[4:0], 3'b000};
      default: sel = head.data;
    endcase
  end

  // output register and packet walker
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      seq       <= '0;
    end else if (load) begin
      if (!empty) begin
        out_valid   <= 1'b1;
        out_byte    <= in_hdr ? sel : head.data;
        packet_last <= !in_hdr && head.plast;
        frame_last  <= !in_hdr && head.flast;
        if (in_hdr) begin
          idx <= idx + 5'd1;
        end else begin
          idx <= '0;
          if (head.hdr) begin
            seq <= seq + 16'd1;
          end
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### design/aac_rtp_packetizer_top.sv
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    data_byte, frame_length, timestamp_ms
// out      out  out_valid/out_ready  out_byte, packet_last, frame_last
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a byte inside a frame is taken and queued in the same cycle while the queue has room
// the first byte of a frame is accepted, then the input is held through the
// timestamp wrap divider, the rate multiply and the queue write of that byte
// with cycle_ms at zero the divider is skipped
// each packet prefix adds 20 output bytes, emitted from the back end
// reset is synchronous; the output register holds while out_valid is high and out_ready is low
`default_nettype none
`include "assert_macros.svh"
module aac_rtp_packetizer_top #(
  parameter int QUEUE_DEPTH = aacrtp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  data_byte,
  input  wire  [12:0] frame_length,
  input  wire  [31:0] timestamp_ms,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_byte,
  output logic        packet_last,
  output logic        frame_last,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data
);
  import aacrtp_pkg::*;

  logic [10:0] mtu_size;
  logic [16:0] sample_rate;
  logic [6:0]  payload_type;
  logic [7:0]  channel_id;
  logic [31:0] stream_ssrc;
  logic [31:0] cycle_ms;

  entry_t wdata;
  entry_t head;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mtu_size     <= 11'd1400;
      sample_rate  <= 17'd44100;
      payload_type <= 7'd96;
      channel_id   <= 8'd0;
      stream_ssrc  <= 32'd0;
      cycle_ms     <= 32'hFFFF_FFFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MTU:     mtu_size     <= cfg_data[10:0];
        REG_RATE:    sample_rate  <= cfg_data[16:0];
        REG_PT:      payload_type <= cfg_data[6:0];
        REG_CHANNEL: channel_id   <= cfg_data[7:0];
        REG_SSRC:    stream_ssrc  <= cfg_data;
        REG_CYCLE:   cycle_ms     <= cfg_data;
        default:     ;
      endcase
    end
  end

  aacrtp_front u_front (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .frame_length, .timestamp_ms,
    .mtu_size, .sample_rate, .cycle_ms, .push, .wdata, .full
  );

  aacrtp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .wdata, .full, .pop, .rdata(head), .empty
  );

  aacrtp_back u_back (
    .clk, .rst, .head, .empty, .pop, .payload_type, .channel_id, .stream_ssrc,
    .out_valid, .out_ready, .out_byte, .packet_last, .frame_last
  );

  // checks
  `ASSERT_ALWAYS(a_no_push_full, clk, rst, !(push && full))
  `ASSERT_ALWAYS(a_frame_ends_packet, clk, rst, !(out_valid && frame_last && !packet_last))
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_byte))
endmodule
`default_nettype wire

### verif/aac_rtp_packetizer_checker.sv
`default_nettype none
module aac_rtp_packetizer_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_ready,
  input  wire  [7:0]  data_byte,
  input  wire  [12:0] frame_length,
  input  wire  [31:0] timestamp_ms,
  input  wire         out_valid,
  input  wire         out_ready,
  input  wire  [7:0]  out_byte,
  input  wire         packet_last,
  input  wire         frame_last,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  output int          fails,
  output int          pending
);
  import aacrtp_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       plast;
    logic       flast;
  } pkt_word_t;

  pkt_word_t   wire_bytes[$];

  // shadow registers
  logic [10:0] mtu;
  logic [16:0] rate;
  logic [6:0]  ptype;
  logic [7:0]  chan;
  logic [31:0] ssrc;
  logic [31:0] wrap_ms;
  // shadow packetizer state
  logic [15:0] seq;
  logic [31:0] rtp;
  logic [12:0] fsize;
  logic [12:0] frame_left;
  logic [10:0] frag_left;

  assign pending = wire_bytes.size();

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  task automatic push_word(input logic [7:0] v, input logic pl, input logic fl);
    pkt_word_t w;
    w.value = v;
    w.plast = pl;
    w.flast = fl;
    wire_bytes.push_back(w);
  endtask

  // expected packet bytes for one accepted frame byte
  task automatic packetize(input logic [7:0] d, input logic [12:0] flen, input logic [31:0] ms);
    logic [31:0] t;
    logic [63:0] prod;
    logic [31:0] maxpl;
    logic [31:0] chunk;
    logic [15:0] len;
    logic        mark;
    if (frame_left == 0) begin
      // zero-length frame start is dropped
      if (flen == 0) return;
      fsize = flen;
      frame_left = flen;
      frag_left = 0;
      t = (wrap_ms != 0) ? (ms % wrap_ms) : ms;
      prod = 64'(rate / 17'd1000) * 64'(t);
      rtp = prod[31:0];
    end
    if (frag_left == 0) begin
      // payload per fragment saturates to one byte on tiny mtu
      maxpl = (mtu > 11'd20) ? 32'(mtu) - 32'd20 : 32'd1;
      chunk = (32'(frame_left) <= maxpl) ? 32'(frame_left) : maxpl;
      mark = (chunk == 32'(frame_left));
      len = 16'(chunk + 32'd16);
      push_word(DOLLAR_BYTE, 0, 0);
      push_word(chan, 0, 0);
      push_word(len[15:8], 0, 0);
      push_word(len[7:0], 0, 0);
      push_word(RTP_VER_BYTE, 0, 0);
      push_word({mark, ptype}, 0, 0);
      push_word(seq[15:8], 0, 0);
      push_word(seq[7:0], 0, 0);
      push_word(rtp[31:24], 0, 0);
      push_word(rtp[23:16], 0, 0);
      push_word(rtp[15:8], 0, 0);
      push_word(rtp[7:0], 0, 0);
      push_word(ssrc[31:24], 0, 0);
      push_word(ssrc[23:16], 0, 0);
      push_word(ssrc[15:8], 0, 0);
      push_word(ssrc[7:0], 0, 0);
      push_word(8'h00, 0, 0);
      push_word(AU_LEN_BYTE, 0, 0);
      push_word(8'(fsize >> 5), 0, 0);
      push_word({fsize[4:0], 3'b000}, 0, 0);
      seq = seq + 16'd1;
      frag_left = chunk[10:0];
    end
    frag_left = frag_left - 11'd1;
    frame_left = frame_left - 13'd1;
    push_word(d, frag_left == 0, frame_left == 0);
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    pkt_word_t want;
    if (rst) begin
      mtu = 11'd1400;
      rate = 17'd44100;
      ptype = 7'd96;
      chan = 8'd0;
      ssrc = 32'd0;
      wrap_ms = 32'hFFFF_FFFF;
      seq = 0;
      rtp = 0;
      fsize = 0;
      frame_left = 0;
      frag_left = 0;
      wire_bytes.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MTU:     mtu = cfg_data[10:0];
          REG_RATE:    rate = cfg_data[16:0];
          REG_PT:      ptype = cfg_data[6:0];
          REG_CHANNEL: chan = cfg_data[7:0];
          REG_SSRC:    ssrc = cfg_data;
          REG_CYCLE:   wrap_ms = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) packetize(data_byte, frame_length, timestamp_ms);
      // compare each output word against the oldest expectation
      if (out_valid && out_ready) begin
        if (wire_bytes.size() == 0) begin
          report("unexpected word", out_byte, 8'h00);
        end else begin
          want = wire_bytes.pop_front();
          if (out_byte !== want.value) report("out_byte", out_byte, want.value);
          if (packet_last !== want.plast) report("packet_last", 8'(packet_last), 8'(want.plast));
          if (frame_last !== want.flast) report("frame_last", 8'(frame_last), 8'(want.flast));
        end
      end
    end
  end

endmodule
`default_nettype wire

### verif/tb_aac_rtp_packetizer_top.sv
`default_nettype none
module tb_aac_rtp_packetizer_top;
  import aacrtp_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam int STALL_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic [12:0] frame_length = '0;
  logic [31:0] timestamp_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        packet_last;
  logic        frame_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fails;
  int          pending;
  logic        calm = 1'b0;
  int          out_hold = 0;
  int          quiet_cycles = 0;

  aac_rtp_packetizer_top i_dut (.*);

  aac_rtp_packetizer_checker i_chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      out_hold <= 0;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready <= (out_hold == 1);
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_hold <= $urandom_range(1, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("aac_rtp_packetizer_top test failed");
      $finish;
    end
  end

  // one frame byte; valid stays up when the next word follows at once
  task automatic send_byte(input logic [7:0] d, input logic [12:0] fl, input logic [31:0] ms);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    data_byte <= d;
    frame_length <= fl;
    timestamp_ms <= ms;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_frame(input int n, input logic [31:0] ms);
    for (int k = 0; k < n; k++)
      send_byte($urandom, (k == 0) ? 13'(n) : 13'($urandom), (k == 0) ? ms : $urandom);
  endtask

  // register write only once the block has drained
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, shortest frame, dropped zero-length start
    send_frame(1, 32'd0);
    send_byte(8'hFF, 13'd0, 32'hFFFF_FFFF);
    send_byte(8'h00, 13'd2, 32'hFFFF_FFFF);
    send_byte(8'hFF, 13'h1FFF, 32'h0);
    // frame cut into two fragments at an mtu of 64
    write_reg(REG_MTU, 32'd64);
    send_frame(60, 32'hFFFF_FFFF);
    // tiny mtu saturates to one payload byte
    write_reg(REG_MTU, 32'd5);
    write_reg(REG_CHANNEL, 32'd255);
    write_reg(REG_PT, 32'd127);
    write_reg(REG_SSRC, 32'hFFFF_FFFF);
    send_frame(3, 32'd1234);
    write_reg(REG_MTU, 32'd21);
    write_reg(REG_RATE, 32'd96000);
    write_reg(REG_CYCLE, 32'd0);
    send_frame(3, 32'hFFFF_FFFF);
    write_reg(REG_MTU, 32'd64);
    write_reg(REG_RATE, 32'd8000);
    write_reg(REG_CYCLE, 32'd1);
    write_reg(REG_PT, 32'd0);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_frame(20, 32'd77);

    // random phases, the last one without idling
    for (int p = 0; p < 6; p++) begin
      calm = (p == 5);
      case ($urandom_range(0, 3))
        0: write_reg(REG_MTU, 32'd64);
        1: write_reg(REG_MTU, 32'd1500);
        2: write_reg(REG_MTU, $urandom_range(0, 40));
        default: write_reg(REG_MTU, $urandom_range(64, 1500));
      endcase
      write_reg(REG_RATE, $urandom_range(0, 1) ? $urandom_range(8000, 96000) : 32'd96000);
      write_reg(REG_PT, $urandom_range(0, 127));
      write_reg(REG_CHANNEL, $urandom_range(0, 255));
      write_reg(REG_SSRC, $urandom);
      case ($urandom_range(0, 3))
        0: write_reg(REG_CYCLE, 32'd0);
        1: write_reg(REG_CYCLE, 32'hFFFF_FFFF);
        2: write_reg(REG_CYCLE, $urandom_range(1, 100));
        default: write_reg(REG_CYCLE, $urandom);
      endcase
      n = 0;
      while (n < 30) begin
        if ($urandom_range(0, 9) == 0) begin
          // stray zero-length start, ignored by the block
          send_byte($urandom, 13'd0, $urandom);
        end else begin
          int len;
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 120) : $urandom_range(1, 24);
          send_frame(len, $urandom);
          n += len;
        end
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("aac_rtp_packetizer_top test passed");
    end else begin
      $display("aac_rtp_packetizer_top test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+design
design/aacrtp_pkg.sv
design/aacrtp_queue.sv
design/aacrtp_front.sv
design/aacrtp_back.sv
design/aac_rtp_packetizer_top.sv
verif/aac_rtp_packetizer_checker.sv
verif/tb_aac_rtp_packetizer_top.sv
